// ===== hdl/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg: shared types and constants of the hub torque frame decoder
// Holds the frame layout, the register indexes and the status struct that
// passes between the framer and the top level.
// ----------------------------------------------------------------------------
package htfd_pkg;

   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned RAW_W         = 16;
   localparam int unsigned ACC_W         = 16;
   localparam int unsigned LEVEL_W       = 12;
   localparam int unsigned PEDAL_W       = 7;
   localparam int unsigned WHEEL_TIME_W  = 15;
   localparam int unsigned OFFSET_W      = 8;
   localparam int unsigned LIMIT_W       = 12;
   localparam int unsigned WT_LIMIT_W    = 16;
   localparam int unsigned CSR_INDEX_W   = 2;
   localparam int unsigned CSR_DATA_W    = 16;
   localparam int unsigned POS_W         = 3;

   // Decay of the torque filter is one part in 2**FILTER_SHIFT (range 1 to 4).
   localparam int unsigned FILTER_SHIFT  = 4;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

   // Frame position: 0 means no frame open, 6 means the checksum byte is next.
   localparam logic [POS_W-1:0] POS_IDLE    = 3'd0;
   localparam logic [POS_W-1:0] POS_FIRST   = 3'd1;
   localparam logic [POS_W-1:0] POS_LAST    = 3'd6;

   // Reset values of the configuration registers.
   localparam logic [OFFSET_W-1:0]   RAW_ZERO_RST         = 8'd145;
   localparam logic [LIMIT_W-1:0]    TORQUE_LIMIT_RST     = 12'd1024;
   localparam logic [WT_LIMIT_W-1:0] WHEEL_TIME_LIMIT_RST = 16'd4501;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_RAW_ZERO         = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TORQUE_LIMIT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL_TIME_LIMIT = 2'd2;

   // What the framer reports about the byte that sits in the input register.
   typedef struct packed {
      logic                  last;       // byte is the checksum byte of a frame
      logic                  sum_ok;     // running sum equals this byte
      logic [RAW_W-1:0]      raw_torque; // frame bytes one and two
      logic [BYTE_W-1:0]     pedal_byte; // frame byte three
      logic [BYTE_W-1:0]     wheel_hi;   // frame byte four
      logic [BYTE_W-1:0]     wheel_lo;   // frame byte five
   } frame_info_type;

endpackage

// ===== hdl/htfd_framer.sv =====
// ----------------------------------------------------------------------------
// htfd_framer: frame alignment and checksum
// Tracks the position inside a seven-byte frame, stores the data bytes and
// keeps the 8-bit running sum for the checksum compare.
// ----------------------------------------------------------------------------
module htfd_framer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  logic [htfd_pkg::BYTE_W-1:0]       rx_byte,
   output htfd_pkg::frame_info_type          info
);
   import htfd_pkg::*;

   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;
   logic [BYTE_W-1:0] sum_ff;
   logic [BYTE_W-1:0] sum_in;
   logic [BYTE_W-1:0] bytes_ff [POS_FIRST:POS_LAST-1];

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (fire) begin
         if (pos_ff == POS_IDLE) begin
            if (rx_byte == SYNC_BYTE) begin
               pos_in = POS_FIRST;
               sum_in = rx_byte;
            end
         end else if (pos_ff == POS_LAST) begin
            pos_in = POS_IDLE;
         end else begin
            pos_in = pos_ff + POS_FIRST;
            sum_in = sum_ff + rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_IDLE;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   // Data bytes carry no reset; each is written before its frame is checked.
   always_ff @(posedge clock) begin
      if (fire && pos_ff != POS_IDLE && pos_ff != POS_LAST) begin
         bytes_ff[pos_ff] <= rx_byte;
      end
   end

   always_comb begin
      info.last       = (pos_ff == POS_LAST);
      info.sum_ok     = (sum_ff == rx_byte);
      info.raw_torque = {bytes_ff[1], bytes_ff[2]};
      info.pedal_byte = bytes_ff[3];
      info.wheel_hi   = bytes_ff[4];
      info.wheel_lo   = bytes_ff[5];
   end

`ifndef ASSERT_OFF
   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("frame position beyond the checksum byte");

   a_open_on_sync : assert property (@(posedge clock) disable iff (reset)
      (fire && pos_ff == POS_IDLE && rx_byte != SYNC_BYTE) |=> pos_ff == POS_IDLE)
      else $error("frame opened on a byte other than the sync byte");

   a_close_after_check : assert property (@(posedge clock) disable iff (reset)
      (fire && pos_ff == POS_LAST) |=> (pos_ff == POS_IDLE && $stable(sum_ff)))
      else $error("frame not closed after its checksum byte");
`endif

endmodule

// ===== hdl/htfd_torque.sv =====
// ----------------------------------------------------------------------------
// htfd_torque: leaky torque accumulator
// Decays the accumulator by one sixteenth per good frame, then adds the
// offset-corrected raw torque or, for an implausible value, decays by one.
// ----------------------------------------------------------------------------
module htfd_torque (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              update,
   input  logic [htfd_pkg::RAW_W-1:0]        raw_torque,
   input  logic [htfd_pkg::OFFSET_W-1:0]     raw_zero,
   input  logic [htfd_pkg::LIMIT_W-1:0]      torque_limit,
   output logic [htfd_pkg::LEVEL_W-1:0]      torque_level
);
   import htfd_pkg::*;

   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] acc_in;
   logic [ACC_W-1:0] acc_decayed;
   logic [RAW_W-1:0] delta;
   logic [ACC_W:0]   acc_sum;
   logic             plausible;
   logic [ACC_W-1:0] level_wide;

   always_comb begin
      acc_decayed = acc_ff - (acc_ff >> FILTER_SHIFT);
      plausible   = ({{(RAW_W-OFFSET_W){1'b0}}, raw_zero} < raw_torque) &&
                    (raw_torque < {{(RAW_W-LIMIT_W){1'b0}}, torque_limit});
      delta       = raw_torque - {{(RAW_W-OFFSET_W){1'b0}}, raw_zero};
      acc_sum     = {1'b0, acc_decayed} + {1'b0, delta};
      acc_in      = acc_ff;
      if (update) begin
         if (plausible) begin
            acc_in = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
         end else if (acc_decayed != '0) begin
            acc_in = acc_decayed - ACC_W'(1);
         end else begin
            acc_in = acc_decayed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      level_wide = acc_ff >> FILTER_SHIFT;
      if (level_wide > {{(ACC_W-LEVEL_W){1'b0}}, {LEVEL_W{1'b1}}}) begin
         torque_level = {LEVEL_W{1'b1}};
      end else begin
         torque_level = level_wide[LEVEL_W-1:0];
      end
   end

endmodule

// ===== hdl/hub_torque_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// hub_torque_frame_decoder: hub sensor serial frame decoder
// Aligns seven-byte frames in the received byte stream, checks their sum and
// keeps pedal, wheel and filtered torque values from the good ones.
// ----------------------------------------------------------------------------
// The result of a frame is offered in the cycle after its checksum beat is processed.
// Throughput: one byte beat per cycle, set by the single input register stage.
// Only the checksum beat waits for a free result register; other beats never
// stall on the result side.
// Reset (synchronous, active high) closes any open frame, clears the torque
// accumulator and held values and restores the register reset values.
module hub_torque_frame_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [htfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [htfd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // received byte channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [htfd_pkg::BYTE_W-1:0]          req_rx_byte,
   // decoded frame channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_frame_ok,
   output logic [htfd_pkg::PEDAL_W-1:0]         rsp_pedal_position,
   output logic                                 rsp_pedals_turning,
   output logic [htfd_pkg::LEVEL_W-1:0]         rsp_torque_level,
   output logic                                 rsp_wheel_turning,
   output logic [htfd_pkg::WHEEL_TIME_W-1:0]    rsp_wheel_time
);
   import htfd_pkg::*;

   // Configuration registers. The port always takes a beat; writes to an
   // unused index are dropped.
   logic [OFFSET_W-1:0]   raw_zero_ff;
   logic [LIMIT_W-1:0]    torque_limit_ff;
   logic [WT_LIMIT_W-1:0] wheel_time_limit_ff;

   // Input register stage holding one received byte.
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [BYTE_W-1:0]     in_byte_ff;

   // Result register and the held values it presents.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  frame_ok_ff;
   logic [PEDAL_W-1:0]    pedal_ff;
   logic                  pedals_turning_ff;
   logic                  wheel_turning_ff;
   logic [WHEEL_TIME_W-1:0] wheel_time_ff;

   frame_info_type        info;
   logic                  out_free;
   logic                  proc_fire;
   logic                  frame_end;
   logic                  frame_commit;
   logic [WHEEL_TIME_W-1:0] wheel_time_new;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_zero_ff         <= RAW_ZERO_RST;
         torque_limit_ff     <= TORQUE_LIMIT_RST;
         wheel_time_limit_ff <= WHEEL_TIME_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RAW_ZERO:         raw_zero_ff         <= csr_wdata[OFFSET_W-1:0];
            CSR_TORQUE_LIMIT:     torque_limit_ff     <= csr_wdata[LIMIT_W-1:0];
            CSR_WHEEL_TIME_LIMIT: wheel_time_limit_ff <= csr_wdata[WT_LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // The byte in the input register is processed whenever it is present,
   // except that a checksum byte needs the result register to be free (or
   // being emptied in the same cycle). The input register refills at once,
   // so bytes flow back to back.
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign proc_fire    = in_valid_ff && (!info.last || out_free);
   assign frame_end    = proc_fire && info.last;
   assign frame_commit = frame_end && info.sum_ok;
   assign req_ready    = !in_valid_ff || proc_fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   htfd_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .fire    (proc_fire),
      .rx_byte (in_byte_ff),
      .info    (info)
   );

   // The accumulator only moves on a frame whose checksum matched, so its
   // level is presented straight from the register as the held value.
   htfd_torque u_torque (
      .clock         (clock),
      .reset         (reset),
      .update        (frame_commit),
      .raw_torque    (info.raw_torque),
      .raw_zero      (raw_zero_ff),
      .torque_limit  (torque_limit_ff),
      .torque_level  (rsp_torque_level)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Wheel period: seven bits of frame byte four above frame byte five.
   assign wheel_time_new = {info.wheel_hi[BYTE_W-2:0], info.wheel_lo};

   // The held values change only when a result is written, which can only
   // happen while the result register is free, so they double as the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         frame_ok_ff       <= 1'b0;
         pedal_ff          <= '0;
         pedals_turning_ff <= 1'b0;
         wheel_turning_ff  <= 1'b0;
         wheel_time_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (frame_end) begin
            frame_ok_ff <= info.sum_ok;
         end
         if (frame_commit) begin
            pedal_ff          <= info.pedal_byte[PEDAL_W-1:0];
            pedals_turning_ff <= info.pedal_byte[BYTE_W-1];
            wheel_turning_ff  <= info.wheel_hi[BYTE_W-1];
            if ({1'b0, wheel_time_new} < wheel_time_limit_ff) begin
               wheel_time_ff <= wheel_time_new;
            end
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_ok       = frame_ok_ff;
   assign rsp_pedal_position = pedal_ff;
   assign rsp_pedals_turning = pedals_turning_ff;
   assign rsp_wheel_turning  = wheel_turning_ff;
   assign rsp_wheel_time     = wheel_time_ff;

`ifndef ASSERT_OFF
   a_result_from_frame : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff) && $past(info.last))
      else $error("result raised without a checksum byte");

   a_stall_only_on_check : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !req_ready) |-> (info.last && !out_free))
      else $error("input stalled on a byte that needs no result slot");

   a_bad_frame_holds : assert property (@(posedge clock) disable iff (reset)
      (frame_end && !info.sum_ok) |=> ($stable(rsp_torque_level) &&
                                       $stable(wheel_time_ff) && !frame_ok_ff))
      else $error("held values changed on a checksum mismatch");
`endif

endmodule

// ===== test/hub_torque_frame_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hub_torque_frame_decoder_tb: self-checking bench for the hub frame decoder
// Feeds received bytes through the valid/ready byte channel and predicts every
// decoded frame with an independent behavioural model of the framer, the
// checksum and the torque filter. A short table of hand-picked bytes opens the
// run. Randomised frame traffic then follows under several register settings,
// with bursty input, a randomly stalling receiver and one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module hub_torque_frame_decoder_tb;

   import htfd_pkg::*;

   typedef logic [BYTE_W-1:0]      byte_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   // One decoded frame, field for field as the result channel carries it.
   typedef struct packed {
      logic                    frame_ok;
      logic [PEDAL_W-1:0]      pedal_position;
      logic                    pedals_turning;
      logic [LEVEL_W-1:0]      torque_level;
      logic                    wheel_turning;
      logic [WHEEL_TIME_W-1:0] wheel_time;
   } frame_result_type;

   // One row of the directed table. Where pinned is set, the result written in
   // the row is expected instead of the predicted one.
   typedef struct packed {
      byte_type         rx_byte;
      logic             pinned;
      frame_result_type result;
   } stim_row_type;

   localparam int unsigned RESET_CYCLES     = 11;
   localparam int unsigned SETTLE_CYCLES    = 6;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned WATCHDOG_LIMIT   = 3000;
   localparam int unsigned DRAIN_LIMIT      = 3000;
   localparam int unsigned PHASES           = 8;
   localparam int unsigned PHASE_BYTES      = 200;
   localparam int unsigned DIRECTED_COUNT   = 24;

   // The one index that no register answers to.
   localparam csr_index_type CSR_UNUSED = 2'd3;

   localparam frame_result_type NO_RESULT = '0;
   // Checksum failure straight after reset: every held value is still zero.
   localparam frame_result_type MISMATCH_AT_RESET =
      '{1'b0, 7'd0, 1'b0, 12'd0, 1'b0, 15'd0};
   // A frame of all ones: flags set, pedal at its top, torque implausible so
   // the empty filter stays empty, wheel time too large so it is not taken.
   localparam frame_result_type ALL_ONES_FRAME =
      '{1'b1, 7'd127, 1'b1, 12'd0, 1'b1, 15'd0};

   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Bytes outside a frame that are not the sync byte are dropped.
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h7E, 1'b0, NO_RESULT},
      // Frame of zeros whose checksum cannot match the sync byte.
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, MISMATCH_AT_RESET},
      '{8'h80, 1'b0, NO_RESULT},
      // Sync bytes inside an open frame are plain data.
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hFA, 1'b1, ALL_ONES_FRAME},
      // Plausible torque, wheel time one below its limit.
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'h03, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h05, 1'b0, NO_RESULT},
      '{8'h11, 1'b0, NO_RESULT},
      '{8'h94, 1'b0, NO_RESULT},
      '{8'hAC, 1'b0, NO_RESULT}
   };

   // Clock, reset and every input of the block start from known values.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = '0;
   csr_data_type  csr_wdata = '0;

   logic     req_valid   = 1'b0;
   logic     req_ready;
   byte_type req_rx_byte = '0;

   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_frame_ok;
   logic [PEDAL_W-1:0]      rsp_pedal_position;
   logic                    rsp_pedals_turning;
   logic [LEVEL_W-1:0]      rsp_torque_level;
   logic                    rsp_wheel_turning;
   logic [WHEEL_TIME_W-1:0] rsp_wheel_time;

   // Predicted frames that the block has yet to deliver, oldest first.
   frame_result_type expected_frames [$];

   int unsigned fault_count     = 0;
   int unsigned idle_cycles     = 0;
   int unsigned burst_left      = 0;
   int unsigned beats_sent      = 0;
   int unsigned hold_off_asked  = 0;
   int unsigned hold_off_served = 0;

   // Shadow of the configuration registers.
   logic [OFFSET_W-1:0]   cfg_zero     = RAW_ZERO_RST;
   logic [LIMIT_W-1:0]    cfg_limit    = TORQUE_LIMIT_RST;
   logic [WT_LIMIT_W-1:0] cfg_wt_limit = WHEEL_TIME_LIMIT_RST;

   // Shadow of the decoder state.
   logic [POS_W-1:0]        frm_pos       = POS_IDLE;
   byte_type                frm_bytes [6] = '{default: '0};
   byte_type                run_sum       = '0;
   logic [ACC_W-1:0]        torque_acc    = '0;
   logic [PEDAL_W-1:0]      held_pedal    = '0;
   logic                    held_pedals   = 1'b0;
   logic                    held_wheel    = 1'b0;
   logic [WHEEL_TIME_W-1:0] held_wt       = '0;

   hub_torque_frame_decoder u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_pedal_position (rsp_pedal_position),
      .rsp_pedals_turning (rsp_pedals_turning),
      .rsp_torque_level   (rsp_torque_level),
      .rsp_wheel_turning  (rsp_wheel_turning),
      .rsp_wheel_time     (rsp_wheel_time)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Advances the shadow framer by one received byte. Returns 1 when the byte
   // closes a frame, with the decoded frame in r.
   function automatic bit decode_byte(input byte_type b, output frame_result_type r);
      int unsigned raw;
      int unsigned wt;
      int unsigned acc;
      int unsigned level;
      r = '0;
      if (frm_pos == POS_IDLE) begin
         if (b == SYNC_BYTE) begin
            frm_bytes[0] = b;
            run_sum      = b;
            frm_pos      = POS_FIRST;
         end
         return 1'b0;
      end
      if (frm_pos < POS_LAST) begin
         frm_bytes[frm_pos] = b;
         run_sum            = run_sum + b;
         frm_pos            = frm_pos + POS_FIRST;
         return 1'b0;
      end

      // This is the checksum byte: the frame closes whatever the outcome.
      frm_pos    = POS_IDLE;
      r.frame_ok = (run_sum == b);
      if (r.frame_ok) begin
         raw         = {16'd0, frm_bytes[1], frm_bytes[2]};
         wt          = {17'd0, frm_bytes[4][6:0], frm_bytes[5]};
         held_pedal  = frm_bytes[3][6:0];
         held_pedals = frm_bytes[3][7];
         held_wheel  = frm_bytes[4][7];
         // Leaky sum: lose one sixteenth, then add the offset-corrected raw
         // value if it is plausible, or else drop by one towards zero.
         acc = {16'd0, torque_acc};
         acc = acc - (acc >> FILTER_SHIFT);
         if ({24'd0, cfg_zero} < raw && raw < {20'd0, cfg_limit}) begin
            acc = acc + (raw - {24'd0, cfg_zero});
            if (acc > 32'h0000_FFFF) acc = 32'h0000_FFFF;
         end else if (acc > 0) begin
            acc = acc - 1;
         end
         torque_acc = acc[ACC_W-1:0];
         // An implausibly long wheel period keeps the previous one.
         if (wt < {16'd0, cfg_wt_limit}) held_wt = wt[WHEEL_TIME_W-1:0];
      end

      level = {16'd0, torque_acc} >> FILTER_SHIFT;
      if (level > 4095) level = 4095;
      r.pedal_position = held_pedal;
      r.pedals_turning = held_pedals;
      r.torque_level   = level[LEVEL_W-1:0];
      r.wheel_turning  = held_wheel;
      r.wheel_time     = held_wt;
      return 1'b1;
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // Offers one byte beat and waits for its acceptance. The sender works in
   // bursts: when one is used up, valid drops for a random gap, which may be
   // empty, before the next burst starts.
   task automatic send_byte(input byte_type b, input bit pinned = 1'b0,
                            input frame_result_type pinned_result = '0);
      int unsigned gap;
      frame_result_type r;
      if (burst_left == 0) begin
         case ($urandom_range(0, 7))
            0, 1:    gap = 0;
            7:       gap = $urandom_range(10, 24);
            default: gap = $urandom_range(1, 4);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 24);
      end
      burst_left  = burst_left - 1;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      beats_sent = beats_sent + 1;
      if (decode_byte(b, r)) expected_frames.push_back(pinned ? pinned_result : r);
   endtask

   // Takes valid down and waits until every predicted frame has come back or the drain limit runs out.
   // The loop waits on the clock before it checks, so valid is never lowered and raised in one step.
   task automatic wait_results();
      int unsigned n;
      n = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         n = n + 1;
      end while (expected_frames.size() != 0 && n < DRAIN_LIMIT);
   endtask

   // Leaves valid high for the next write; the caller lowers it afterwards.
   task automatic write_reg(input csr_index_type idx, input csr_data_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RAW_ZERO:         cfg_zero     = data[OFFSET_W-1:0];
         CSR_TORQUE_LIMIT:     cfg_limit    = data[LIMIT_W-1:0];
         CSR_WHEEL_TIME_LIMIT: cfg_wt_limit = data[WT_LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // Writes the register setting of one phase. The block must be idle. The
   // random settings leave junk in the upper data bits of the narrow registers.
   task automatic load_setting(input int unsigned ph);
      csr_data_type off;
      csr_data_type lim;
      csr_data_type wtl;
      case (ph)
         1: begin off = 16'd0;   lim = 16'd4095; wtl = 16'd32768; end
         2: begin off = 16'd255; lim = 16'd0;    wtl = 16'd0;     end
         3, 5: begin
            off = csr_data_type'($urandom_range(0, 65535));
            lim = csr_data_type'($urandom_range(0, 65535));
            wtl = csr_data_type'($urandom_range(0, 32768));
         end
         4: begin off = 16'd0;   lim = 16'd4095; wtl = 16'd1;     end
         6: begin off = 16'd255; lim = 16'd4095; wtl = 16'd32767; end
         default: begin
            off = csr_data_type'(RAW_ZERO_RST);
            lim = csr_data_type'(TORQUE_LIMIT_RST);
            wtl = WHEEL_TIME_LIMIT_RST;
         end
      endcase
      write_reg(CSR_RAW_ZERO, off);
      write_reg(CSR_TORQUE_LIMIT, lim);
      write_reg(CSR_WHEEL_TIME_LIMIT, wtl);
      // A write to the unused index must leave all three registers alone.
      write_reg(CSR_UNUSED, csr_data_type'($urandom_range(0, 65535)));
      csr_valid <= 1'b0;
   endtask

   // Raw torque values cluster around the plausibility window of the current
   // setting, its edges included, with some drawn from the whole range.
   function automatic logic [RAW_W-1:0] pick_raw();
      int unsigned off;
      int unsigned lim;
      int unsigned raw;
      off = {24'd0, cfg_zero};
      lim = {20'd0, cfg_limit};
      case ($urandom_range(0, 4))
         0: raw = $urandom_range(0, 65535);
         1, 2: raw = (lim > off + 1) ? $urandom_range(off + 1, lim - 1)
                                     : $urandom_range(0, 4095);
         3: begin
            case ($urandom_range(0, 3))
               0:       raw = off;
               1:       raw = off + 1;
               2:       raw = lim - 1;
               default: raw = lim;
            endcase
         end
         default: raw = $urandom_range(0, 4095);
      endcase
      return raw[RAW_W-1:0];
   endfunction

   // Wheel periods likewise favour the accepted range and the limit itself.
   function automatic logic [WHEEL_TIME_W-1:0] pick_wheel_time();
      int unsigned lim;
      int unsigned wt;
      lim = {16'd0, cfg_wt_limit};
      if (lim > 32768) lim = 32768;
      case ($urandom_range(0, 3))
         0:       wt = $urandom_range(0, 32767);
         1, 2:    wt = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
         default: wt = {16'd0, cfg_wt_limit} + $urandom_range(0, 2) - 1;
      endcase
      return wt[WHEEL_TIME_W-1:0];
   endfunction

   // Sends one piece of random traffic: mostly well-formed frames, some with
   // a broken checksum, some loose bytes and some frames cut short. A cut frame
   // swallows the start of whatever follows, so alignment is lost and regained.
   task automatic send_chunk();
      byte_type         body [5];
      byte_type         sum;
      logic [RAW_W-1:0] raw;
      logic [WHEEL_TIME_W-1:0] wt;
      int unsigned      pick;
      int unsigned      n;
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
         raw     = pick_raw();
         wt      = pick_wheel_time();
         body[0] = raw[15:8];
         body[1] = raw[7:0];
         body[2] = byte_type'($urandom_range(0, 255));
         body[3] = {1'($urandom_range(0, 1)), wt[14:8]};
         body[4] = wt[7:0];
         sum     = SYNC_BYTE;
         foreach (body[k]) sum = sum + body[k];
         if (pick >= 72) sum = sum + byte_type'($urandom_range(1, 255));
         send_byte(SYNC_BYTE);
         foreach (body[k]) send_byte(body[k]);
         send_byte(sum);
      end else if (pick < 92) begin
         n = $urandom_range(1, 5);
         repeat (n) send_byte(byte_type'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 5);
         send_byte(SYNC_BYTE);
         repeat (n) send_byte(byte_type'($urandom_range(0, 255)));
      end
   endtask

   // -------------------------------------------------------------------------
   // Receiver pacing
   // -------------------------------------------------------------------------

   // Ready follows a pattern of its own, drawn anew at random intervals:
   // always ready, coin toss, mostly stalled or a fixed two-in-three cadence.
   // When the main sequence asks for it, ready stays low for a long stretch so
   // that the result register fills and the checksum beat backs up the input.
   initial begin : rsp_pacing
      int unsigned mode;
      int unsigned left;
      @(posedge clock);
      forever begin
         if (hold_off_served != hold_off_asked) begin
            hold_off_served = hold_off_served + 1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 4);
            left = $urandom_range(4, 64);
            while (left > 0) begin
               case (mode)
                  1:       rsp_ready <= 1'($urandom_range(0, 1));
                  2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                  3:       rsp_ready <= ((left % 3) != 0);
                  default: rsp_ready <= 1'b1;
               endcase
               left = left - 1;
               @(posedge clock);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fault_count = fault_count + 1;
      end
   endfunction

   // Values are sampled just after the edge, before any update of that edge
   // lands, so each result beat is seen exactly once.
   always @(posedge clock) begin : rsp_checker
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frames.size() == 0) begin
            $error("result beat arrived with no frame pending");
            fault_count = fault_count + 1;
         end else begin
            want = expected_frames.pop_front();
            check_field("frame_ok",       want.frame_ok,       rsp_frame_ok);
            check_field("pedal_position", want.pedal_position, rsp_pedal_position);
            check_field("pedals_turning", want.pedals_turning, rsp_pedals_turning);
            check_field("torque_level",   want.torque_level,   rsp_torque_level);
            check_field("wheel_turning",  want.wheel_turning,  rsp_wheel_turning);
            check_field("wheel_time",     want.wheel_time,     rsp_wheel_time);
         end
      end
   end

   // Ends a hung run: counts cycles in which no channel moves a beat. The
   // longest legitimate quiet stretch is the receiver hold-off.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------

   initial begin : main_sequence
      int unsigned ph;
      int unsigned phase_start;
      bit          paused;
      paused = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed bytes at the reset values of the registers.
      foreach (DIRECTED_ROWS[i])
         send_byte(DIRECTED_ROWS[i].rx_byte, DIRECTED_ROWS[i].pinned,
                   DIRECTED_ROWS[i].result);

      // Random traffic, one register setting per phase. Before each write the
      // block is drained and then left to settle so that its pipeline empties.
      for (ph = 0; ph < PHASES; ph++) begin
         wait_results();
         repeat (SETTLE_CYCLES) @(posedge clock);
         load_setting(ph);
         phase_start = beats_sent;
         while (beats_sent - phase_start < PHASE_BYTES) begin
            if (ph == 3 && beats_sent - phase_start >= 60 && hold_off_asked == 0)
               hold_off_asked = 1;
            if (ph == 5 && beats_sent - phase_start >= 100 && !paused) begin
               // The sender pauses mid-phase until the block has caught up.
               wait_results();
               paused = 1'b1;
            end
            send_chunk();
         end
      end

      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_frames.size() != 0) begin
         $error("%0d predicted frames never arrived", expected_frames.size());
         fault_count = fault_count + 1;
      end
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/htfd_pkg.sv
hdl/htfd_framer.sv
hdl/htfd_torque.sv
hdl/hub_torque_frame_decoder.sv
test/hub_torque_frame_decoder_tb.sv
